@@ hdl/scbc_pkg.sv @@
// Package for the size-class block cache: widths, defaults, action codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scbc_pkg;
    localparam int NUM_CLASSES     = 20;
    localparam int NEAR_DEPTH      = 16;
    localparam int SHARED_DEPTH    = 64;
    localparam int MIN_CLASS_BYTES = 64;
    localparam int ADDR_BITS       = 48;
    localparam int BYTES_W         = 40;
    localparam int NEAR_LIM_W      = 5;
    localparam int SHARED_LIM_W    = 7;
    localparam int CFG_W           = 7;
    localparam int CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARED_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        ACT_CACHED_GIVE = 3'd0,
        ACT_BACKEND_ALLOC = 3'd1,
        ACT_CACHED_TAKE = 3'd2,
        ACT_BACKEND_RELEASE = 3'd3,
        ACT_IGNORED = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LOOK = 2'd1,
        ST_OUT  = 2'd2
    } t_state;
endpackage
`default_nettype wire

@@ hdl/scbc_req_if.sv @@
// Request channel interface: valid/ready with request fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface scbc_req_if #(parameter int ADDR_W = 48, parameter int BYTES_W = 40);
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
    modport source (output valid, mode, request_bytes, block_address, input ready);
    modport sink   (input valid, mode, request_bytes, block_address, output ready);
endinterface
`default_nettype wire

@@ hdl/scbc_rsp_if.sv @@
// Result channel interface: valid/ready with result fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface scbc_rsp_if #(parameter int ADDR_W = 48, parameter int BYTES_W = 40);
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [ADDR_W-1:0]  result_address;
    logic [BYTES_W-1:0] backend_bytes;
    logic [4:0]         size_class;
    logic               bypassed;
    logic               from_near;
    modport source (output valid, action, result_address, backend_bytes, size_class,
                    bypassed, from_near, input ready);
    modport sink   (input valid, action, result_address, backend_bytes, size_class,
                    bypassed, from_near, output ready);
endinterface
`default_nettype wire

@@ hdl/size_class_block_cache_unit.sv @@
// Size-class block cache: one request at a time, taken in ST_IDLE once the
// last result is taken. On accept it decodes the class and reads the
// stacks' top entries; counts per class sit in small register arrays.
// ST_LOOK decides and writes back; the result waits in the output register
// until taken. Depends on scbc_pkg, scbc_req_if, scbc_rsp_if, scbc_ram.
`timescale 1ns / 1ps
`default_nettype none
module size_class_block_cache_unit #(
    parameter int NUM_CLASSES     = scbc_pkg::NUM_CLASSES,
    parameter int NEAR_DEPTH      = scbc_pkg::NEAR_DEPTH,
    parameter int SHARED_DEPTH    = scbc_pkg::SHARED_DEPTH,
    parameter int MIN_CLASS_BYTES = scbc_pkg::MIN_CLASS_BYTES,
    parameter int ADDR_BITS       = scbc_pkg::ADDR_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [scbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [scbc_pkg::CFG_W-1:0]          i_cfg_data,
    scbc_req_if.sink                                 req,
    scbc_rsp_if.source                               rsp
);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int NPTR_W = (NEAR_DEPTH > 1) ? $clog2(NEAR_DEPTH) : 1;
    localparam int SPTR_W = (SHARED_DEPTH > 1) ? $clog2(SHARED_DEPTH) : 1;
    localparam int NCNT_W = $clog2(NEAR_DEPTH + 1);
    localparam int SCNT_W = $clog2(SHARED_DEPTH + 1);
    localparam int NADDR_W = $clog2(NUM_CLASSES * NEAR_DEPTH + 1);
    localparam int SADDR_W = $clog2(NUM_CLASSES * SHARED_DEPTH + 1);
    localparam int BW = scbc_pkg::BYTES_W;
    localparam int MIN_LOG = $clog2(MIN_CLASS_BYTES);

    scbc_pkg::t_state r_state, n_state;
    logic [scbc_pkg::NEAR_LIM_W-1:0]   r_near_limit;
    logic [scbc_pkg::SHARED_LIM_W-1:0] r_shared_limit;
    logic [NCNT_W-1:0] r_ncnt [NUM_CLASSES];
    logic [SCNT_W-1:0] r_scnt [NUM_CLASSES];

    logic              r_mode;
    logic [BW-1:0]     r_bytes;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CLS_W-1:0]  r_cls;
    logic              r_byp;
    logic [NCNT_W-1:0] r_nc;
    logic [SCNT_W-1:0] r_sc;

    logic [2:0]           r_o_action;
    logic [ADDR_BITS-1:0] r_o_addr;
    logic [BW-1:0]        r_o_bytes;
    logic [4:0]           r_o_cls;
    logic                 r_o_byp;
    logic                 r_o_near;

    // class decode: smallest k with MIN << k >= size
    logic [CLS_W-1:0] c_cls;
    logic             c_byp;
    always_comb begin
        c_cls = '0;
        c_byp = 1'b1;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ((MIN_LOG + k >= BW) ||
                (req.request_bytes <= BW'((64'd1 << (MIN_LOG + k))))) begin
                c_cls = CLS_W'(k);
                c_byp = 1'b0;
            end
        end
        if (req.request_bytes == '0) begin
            c_byp = 1'b1;
            c_cls = '0;
        end
    end

    logic accept;
    assign accept = req.valid && req.ready;
    assign req.ready = (r_state == scbc_pkg::ST_IDLE);

    // read addresses of the stack tops
    logic [NCNT_W-1:0] c_nc;
    logic [SCNT_W-1:0] c_sc;
    logic [NPTR_W-1:0] c_nptr;
    logic [SPTR_W-1:0] c_sptr;
    assign c_nc = r_ncnt[c_cls];
    assign c_sc = r_scnt[c_cls];
    assign c_nptr = NPTR_W'(c_nc - NCNT_W'(1));
    assign c_sptr = SPTR_W'(c_sc - SCNT_W'(1));

    logic [NADDR_W-1:0] near_raddr, near_waddr;
    logic [SADDR_W-1:0] sh_raddr, sh_waddr;
    assign near_raddr = NADDR_W'(c_cls) * NADDR_W'(NEAR_DEPTH) + NADDR_W'(c_nptr);
    assign sh_raddr   = SADDR_W'(c_cls) * SADDR_W'(SHARED_DEPTH) + SADDR_W'(c_sptr);
    assign near_waddr = NADDR_W'(r_cls) * NADDR_W'(NEAR_DEPTH) + NADDR_W'(r_nc[NPTR_W-1:0]);
    assign sh_waddr   = SADDR_W'(r_cls) * SADDR_W'(SHARED_DEPTH) + SADDR_W'(r_sc[SPTR_W-1:0]);

    logic [ADDR_BITS-1:0] near_rdata, sh_rdata;

    // effective limits
    logic [NCNT_W-1:0] eff_near;
    logic [SCNT_W-1:0] eff_sh;
    assign eff_near = (32'(r_near_limit) > NEAR_DEPTH) ? NCNT_W'(NEAR_DEPTH)
                                                       : NCNT_W'(r_near_limit);
    assign eff_sh = (32'(r_shared_limit) > SHARED_DEPTH) ? SCNT_W'(SHARED_DEPTH)
                                                         : SCNT_W'(r_shared_limit);

    // decision in ST_LOOK
    logic ignore, near_push, sh_push, near_pop, sh_pop;
    logic [2:0] d_action;
    logic [ADDR_BITS-1:0] d_addr;
    logic [BW-1:0] d_bytes;
    logic [BW:0] cap;
    assign cap = ((MIN_LOG + 32'(r_cls)) >= BW) ? {1'b1, {BW{1'b0}}}
                 : ((BW + 1)'(1) << (MIN_LOG + 32'(r_cls)));
    always_comb begin
        ignore = r_mode && (r_addr == '0);
        near_pop = 1'b0; sh_pop = 1'b0; near_push = 1'b0; sh_push = 1'b0;
        d_action = scbc_pkg::ACT_IGNORED;
        d_addr = '0;
        d_bytes = '0;
        if (ignore) begin
            d_action = scbc_pkg::ACT_IGNORED;
        end else if (r_byp) begin
            if (!r_mode) begin
                d_action = scbc_pkg::ACT_BACKEND_ALLOC;
                d_bytes = r_bytes;
            end else begin
                d_action = scbc_pkg::ACT_BACKEND_RELEASE;
                d_addr = r_addr;
            end
        end else if (!r_mode) begin
            if (r_nc != '0) begin
                near_pop = 1'b1;
                d_action = scbc_pkg::ACT_CACHED_GIVE;
                d_addr = near_rdata;
            end else if (r_sc != '0) begin
                sh_pop = 1'b1;
                d_action = scbc_pkg::ACT_CACHED_GIVE;
                d_addr = sh_rdata;
            end else begin
                d_action = scbc_pkg::ACT_BACKEND_ALLOC;
                d_bytes = cap[BW] ? {BW{1'b1}} : cap[BW-1:0];
            end
        end else begin
            if (r_nc < eff_near) begin
                near_push = 1'b1;
                d_action = scbc_pkg::ACT_CACHED_TAKE;
            end else if (r_sc < eff_sh) begin
                sh_push = 1'b1;
                d_action = scbc_pkg::ACT_CACHED_TAKE;
            end else begin
                d_action = scbc_pkg::ACT_BACKEND_RELEASE;
                d_addr = r_addr;
            end
        end
    end

    logic in_look;
    assign in_look = (r_state == scbc_pkg::ST_LOOK);

    scbc_ram #(.WIDTH(ADDR_BITS), .DEPTH(NUM_CLASSES * NEAR_DEPTH)) u_near (
        .i_clk(i_clk), .i_we(in_look && near_push),
        .i_waddr(near_waddr[$clog2(NUM_CLASSES * NEAR_DEPTH)-1:0]), .i_wdata(r_addr),
        .i_raddr(near_raddr[$clog2(NUM_CLASSES * NEAR_DEPTH)-1:0]), .o_rdata(near_rdata)
    );
    scbc_ram #(.WIDTH(ADDR_BITS), .DEPTH(NUM_CLASSES * SHARED_DEPTH)) u_shared (
        .i_clk(i_clk), .i_we(in_look && sh_push),
        .i_waddr(sh_waddr[$clog2(NUM_CLASSES * SHARED_DEPTH)-1:0]), .i_wdata(r_addr),
        .i_raddr(sh_raddr[$clog2(NUM_CLASSES * SHARED_DEPTH)-1:0]), .o_rdata(sh_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            scbc_pkg::ST_IDLE: if (accept) n_state = scbc_pkg::ST_LOOK;
            scbc_pkg::ST_LOOK: n_state = scbc_pkg::ST_OUT;
            scbc_pkg::ST_OUT:  if (rsp.ready) n_state = scbc_pkg::ST_IDLE;
            default:           n_state = scbc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        rsp.valid = (r_state == scbc_pkg::ST_OUT);
    end
    assign rsp.action = r_o_action;
    assign rsp.result_address = r_o_addr;
    assign rsp.backend_bytes = r_o_bytes;
    assign rsp.size_class = r_o_cls;
    assign rsp.bypassed = r_o_byp;
    assign rsp.from_near = r_o_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scbc_pkg::ST_IDLE;
            r_near_limit <= scbc_pkg::NEAR_LIM_W'(16);
            r_shared_limit <= scbc_pkg::SHARED_LIM_W'(64);
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_ncnt[i] <= '0;
                r_scnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    scbc_pkg::REG_NEAR_LIMIT:
                        r_near_limit <= i_cfg_data[scbc_pkg::NEAR_LIM_W-1:0];
                    scbc_pkg::REG_SHARED_LIMIT:
                        r_shared_limit <= i_cfg_data[scbc_pkg::SHARED_LIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_look) begin
                if (near_pop)  r_ncnt[r_cls] <= r_nc - NCNT_W'(1);
                if (near_push) r_ncnt[r_cls] <= r_nc + NCNT_W'(1);
                if (sh_pop)    r_scnt[r_cls] <= r_sc - SCNT_W'(1);
                if (sh_push)   r_scnt[r_cls] <= r_sc + SCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= req.mode;
            r_bytes <= req.request_bytes;
            r_addr  <= req.block_address[ADDR_BITS-1:0];
            r_cls   <= c_byp ? '0 : c_cls;
            r_byp   <= c_byp;
            r_nc    <= c_nc;
            r_sc    <= c_sc;
        end
        if (in_look) begin
            r_o_action <= d_action;
            r_o_addr   <= d_addr;
            r_o_bytes  <= d_bytes;
            r_o_cls    <= (ignore || r_byp) ? 5'd0 : 5'(r_cls);
            r_o_byp    <= !ignore && r_byp;
            r_o_near   <= near_pop || near_push;
        end
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_look |-> !((near_pop || sh_pop) && (near_push || sh_push))) else $error("pop and push");
    a_near_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_look && near_push |-> r_nc < NCNT_W'(NEAR_DEPTH)) else $error("near overflow");
    a_sh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_look && sh_push |-> r_sc < SCNT_W'(SHARED_DEPTH)) else $error("shared overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(r_o_action)) else $error("result lost");
endmodule
`default_nettype wire

@@ hdl/scbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module scbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
